@@ rtl/hsa_pkg.sv @@
package hsa_pkg;

    // Field widths fixed by the interface
    localparam int SUM_W        = 32;
    localparam int OLD_W        = 6;
    localparam int REC_W        = 6;
    localparam int SLOT_OUT_W   = 7;
    localparam int NUM_SLOTS_DEF = 64;

    // Start-slot reduction: byte fold width, then reciprocal multiply on the fold
    localparam int FOLD_W       = 16;
    localparam int RECIP_W      = 17;
    localparam int CNT_W        = 6;

    localparam logic [SLOT_OUT_W-1:0] NO_SLOT = SLOT_OUT_W'(64);

    // Slots whose number mod 6 is 0 or 1 carry bursts and are never handed out
    localparam logic [63:0] BURST_MASK = 64'h30C3_0C30_C30C_30C3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_SWAP  = 1'b1;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [SUM_W-1:0]  sensor_id;
        logic [OLD_W-1:0]  old_slot;
        logic [REC_W-1:0]  record_index;
    } t_in;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  status;
        logic [REC_W-1:0]      record_index_out;
    } t_out;

    // Datapath operations
    localparam logic [2:0] DP_NOP    = 3'd0;
    localparam logic [2:0] DP_LOAD   = 3'd1;
    localparam logic [2:0] DP_FOLD   = 3'd2;
    localparam logic [2:0] DP_RECIP  = 3'd3;
    localparam logic [2:0] DP_START  = 3'd4;
    localparam logic [2:0] DP_PROBE  = 3'd5;
    localparam logic [2:0] DP_COMMIT = 3'd6;

    // Jump conditions
    localparam logic [2:0] C_NEVER      = 3'd0;
    localparam logic [2:0] C_NO_INPUT   = 3'd1;
    localparam logic [2:0] C_PROBE_MORE = 3'd2;
    localparam logic [2:0] C_OUT_BUSY   = 3'd3;
    localparam logic [2:0] C_ALWAYS     = 3'd4;

    // Program steps
    localparam logic [2:0] STEP_WAIT   = 3'd0;
    localparam logic [2:0] STEP_FOLD   = 3'd1;
    localparam logic [2:0] STEP_RECIP  = 3'd2;
    localparam logic [2:0] STEP_SETUP  = 3'd3;
    localparam logic [2:0] STEP_PROBE  = 3'd4;
    localparam logic [2:0] STEP_COMMIT = 3'd5;
    localparam logic [2:0] STEP_RET    = 3'd6;

    typedef struct packed {
        logic [2:0] dp_op;
        logic [2:0] cond;
        logic [2:0] target;
    } t_uword;

    typedef struct packed {
        logic       in_ready;
        logic [2:0] dp_op;
    } t_ctl;

    typedef struct packed {
        logic probe_more;
        logic out_busy;
    } t_flags;

    // Control store: jump to target when cond holds, else fall through
    function automatic t_uword ucode(input logic [2:0] step);
        t_uword w;
        unique case (step)
            STEP_WAIT:   w = '{dp_op: DP_LOAD,   cond: C_NO_INPUT,   target: STEP_WAIT};
            STEP_FOLD:   w = '{dp_op: DP_FOLD,   cond: C_NEVER,      target: STEP_WAIT};
            STEP_RECIP:  w = '{dp_op: DP_RECIP,  cond: C_NEVER,      target: STEP_WAIT};
            STEP_SETUP:  w = '{dp_op: DP_START,  cond: C_NEVER,      target: STEP_WAIT};
            STEP_PROBE:  w = '{dp_op: DP_PROBE,  cond: C_PROBE_MORE, target: STEP_PROBE};
            STEP_COMMIT: w = '{dp_op: DP_COMMIT, cond: C_OUT_BUSY,   target: STEP_COMMIT};
            STEP_RET:    w = '{dp_op: DP_NOP,    cond: C_ALWAYS,     target: STEP_WAIT};
            default:     w = '{dp_op: DP_NOP,    cond: C_ALWAYS,     target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/hsa_sequencer.sv @@
module hsa_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hsa_pkg::t_flags i_flags,
    output hsa_pkg::t_ctl o_ctl
);
    import hsa_pkg::*;

    logic [2:0] r_step;
    logic [2:0] n_step;
    t_uword     word;
    logic       take;

    assign word = ucode(r_step);

    always_comb begin
        unique case (word.cond)
            C_NEVER:      take = 1'b0;
            C_NO_INPUT:   take = !i_in_valid;
            C_PROBE_MORE: take = i_flags.probe_more;
            C_OUT_BUSY:   take = i_flags.out_busy;
            C_ALWAYS:     take = 1'b1;
            default:      take = 1'b1;
        endcase
        n_step = take ? word.target : r_step + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.in_ready = (word.dp_op == DP_LOAD);
    assign o_ctl.dp_op    = word.dp_op;

endmodule

@@ rtl/hsa_datapath.sv @@
module hsa_datapath #(
    parameter int NUM_SLOTS = hsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hsa_pkg::t_ctl            i_ctl,
    input  logic                     i_in_valid,
    input  hsa_pkg::t_in             i_in,
    input  logic [hsa_pkg::SUM_W-1:0] i_hub_id,
    input  logic                     i_out_ready,
    output hsa_pkg::t_flags          o_flags,
    output logic                     o_out_valid,
    output hsa_pkg::t_out            o_out
);
    import hsa_pkg::*;

    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int PROD_W   = FOLD_W + RECIP_W;
    // Reciprocal exact for every fold value below 2^FOLD_W
    localparam int RECIP_SH = FOLD_W + SLOT_W;
    localparam int RECIP_M  = ((1 << RECIP_SH) + NUM_SLOTS - 1) / NUM_SLOTS;
    localparam logic [SLOT_W-1:0]    LAST    = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [NUM_SLOTS-1:0] BURST_N = BURST_MASK[NUM_SLOTS-1:0];
    // Weights of the upper sum bytes, 256^i mod NUM_SLOTS
    localparam logic [FOLD_W-1:0]    K1      = FOLD_W'(256 % NUM_SLOTS);
    localparam logic [FOLD_W-1:0]    K2      = FOLD_W'(65536 % NUM_SLOTS);
    localparam logic [FOLD_W-1:0]    K3      = FOLD_W'(16777216 % NUM_SLOTS);
    localparam logic [FOLD_W-1:0]    N_F     = FOLD_W'(NUM_SLOTS);
    localparam logic [PROD_W-1:0]    M_P     = PROD_W'(RECIP_M);

    logic [SUM_W-1:0]     r_sum;
    logic [FOLD_W-1:0]    r_fold;
    logic [FOLD_W-1:0]    r_quot;
    logic [SLOT_W-1:0]    r_pos;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_hit;
    logic                 r_op;
    logic [OLD_W-1:0]     r_old;
    logic [REC_W-1:0]     r_rec;
    logic [NUM_SLOTS-1:0] r_busy;
    logic [NUM_SLOTS-1:0] n_busy;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [FOLD_W-1:0] fold_sum;
    logic [PROD_W-1:0] prod;
    logic [FOLD_W-1:0] rem_full;
    logic free_now;
    logic out_busy;
    logic commit;
    logic old_ok;

    // Fold the sum bytes with their weights: same residue, at most 16 bits
    assign fold_sum = FOLD_W'(r_sum[7:0]) + FOLD_W'(r_sum[15:8]) * K1
                    + FOLD_W'(r_sum[23:16]) * K2 + FOLD_W'(r_sum[31:24]) * K3;
    assign prod     = PROD_W'(r_fold) * M_P;
    assign rem_full = r_fold - r_quot * N_F;

    assign free_now = !r_busy[r_pos] && !BURST_N[r_pos];
    assign out_busy = r_out_valid && !i_out_ready;
    assign commit   = (i_ctl.dp_op == DP_COMMIT) && !out_busy;
    assign old_ok   = SLOT_OUT_W'(r_old) < SLOT_OUT_W'(NUM_SLOTS);

    assign o_flags.probe_more = !free_now && (r_cnt != CNT_W'(NUM_SLOTS - 1));
    assign o_flags.out_busy   = out_busy;

    always_comb begin
        n_busy = r_busy;
        if (r_hit) begin
            if (r_op == OP_SWAP && old_ok) begin
                n_busy[r_old[SLOT_W-1:0]] = 1'b0;
            end
            n_busy[r_pos] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.dp_op)
            DP_LOAD: begin
                if (i_in_valid) begin
                    r_sum <= i_in.sensor_id + i_hub_id;
                    r_op  <= i_in.opcode;
                    r_old <= i_in.old_slot;
                    r_rec <= i_in.record_index;
                end
            end
            DP_FOLD: begin
                r_fold <= fold_sum;
            end
            DP_RECIP: begin
                r_quot <= FOLD_W'(prod >> RECIP_SH);
            end
            DP_START: begin
                r_pos <= rem_full[SLOT_W-1:0];
                r_cnt <= '0;
                r_hit <= 1'b0;
            end
            DP_PROBE: begin
                if (free_now) begin
                    r_hit <= 1'b1;
                end else begin
                    r_pos <= (r_pos == LAST) ? '0 : r_pos + SLOT_W'(1);
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            DP_COMMIT: begin
                if (commit) begin
                    r_out.slot             <= r_hit ? SLOT_OUT_W'(r_pos) : NO_SLOT;
                    r_out.status           <= r_hit ? ST_OK : ST_FULL;
                    r_out.record_index_out <= r_rec;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_busy      <= n_busy;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ rtl/hashed_slot_allocator.sv @@
// Channel  Direction  Handshake                 Beat
// in       input      i_in_valid / o_in_ready   t_in: opcode, sensor_id, old_slot, record_index
// out      output     o_out_valid / i_out_ready t_out: slot, status, record_index_out
// cfg      input      i_cfg_valid / o_cfg_ready 32-bit hub_id
//
// One request at a time. Between two accepts the sequencer runs one accept step, a
// byte fold and a reciprocal multiply for the start slot, one set-up, one step per
// probed slot (1 .. NUM_SLOTS), commit and return. The result is registered at the
// commit step, so the probe loop over the busy map sets when it becomes valid.
// Reset (synchronous, active low) clears the busy map and hub_id.
// The result sits in an output register; commit of the next request stalls
// while that register still holds an untaken beat.
module hashed_slot_allocator #(
    parameter int NUM_SLOTS = hsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  hsa_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output hsa_pkg::t_out              o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [hsa_pkg::SUM_W-1:0]  i_cfg_data
);
    import hsa_pkg::*;

    logic [SUM_W-1:0] r_hub_id;
    t_ctl             ctl;
    t_flags           flags;

    // Config beats land at any time; the user must issue them only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hub_id <= '0;
        end else if (i_cfg_valid) begin
            r_hub_id <= i_cfg_data;
        end
    end

    // Control store and step counter
    hsa_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_ctl      (ctl)
    );

    // Start-slot reduction, probe pointer, busy map and output register
    hsa_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_hub_id    (r_hub_id),
        .i_out_ready (i_out_ready),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // Accept only in the wait step
    assign o_in_ready = ctl.in_ready;

`ifndef NO_ASSERTIONS
    // A request occupies the sequencer: no second accept right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request accepted back to back");

    // Full status goes with the no-slot code and nothing else
    a_full_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.status == ST_FULL) == (o_out.slot == NO_SLOT)))
        else $error("status and slot disagree");

    // A granted slot is in range and never a burst slot
    a_grant_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_OK) |->
            (o_out.slot < SLOT_OUT_W'(NUM_SLOTS)) && !BURST_MASK[o_out.slot[5:0]])
        else $error("granted slot out of range or reserved");
`endif

endmodule
